// File: src/rpa_pkg.sv
// Shared types and codes of the reference-counted page allocator.
package rpa_pkg;

  // Fixed field widths of the request and response words.
  localparam int PAGE_W   = 14;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int REF_W    = 8;
  localparam int FREE_W   = 15;

  // Saturation limit of the free-page counter.
  localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

  // Operation codes; the two codes above FUNC_READ do nothing.
  localparam logic [FUNC_W-1:0] FUNC_SEED  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_INC   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEC   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 2'd3;

  // Configuration register indexes (word addresses).
  localparam logic REG_FIRST_USABLE = 1'b0;

  // Request word.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PAGE_W-1:0] page;
  } rpa_req_t;

  // Response word.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   alloc_page;
    logic [REF_W-1:0]    ref_count;
    logic [FREE_W-1:0]   free_count;
    logic                page_released;
  } rpa_rsp_t;

  // Configuration seen by the core.
  typedef struct packed {
    logic [PAGE_W-1:0] first_usable_page;
  } rpa_cfg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } rpa_state_e;

endpackage

// File: src/rpa_stream_if.sv
// Valid/ready stream interface that carries one word per handshake.
interface rpa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/rpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rpa_core.sv
// Allocator core: count and link memories, read-modify-write sequencer, result register.
module rpa_core #(
  parameter int NUM_PAGES  = 16384,
  parameter int COUNT_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpa_pkg::rpa_cfg_t cfg_i,
  rpa_stream_if.sink       req_i,
  rpa_stream_if.source     rsp_o
);
  import rpa_pkg::*;

  localparam int AW   = $clog2(NUM_PAGES);
  localparam int CW   = COUNT_BITS;
  localparam int CMPW = ((AW > PAGE_W) ? AW : PAGE_W) + 1;
  localparam int NW   = PAGE_W + 1;

  localparam logic [AW-1:0]   CLR_LAST  = AW'(NUM_PAGES - 1);
  localparam logic [CMPW-1:0] PAGE_LIM  = CMPW'(NUM_PAGES);
  localparam logic [CW-1:0]   COUNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0]   COUNT_ONE = CW'(1);

  rpa_state_e state_q, state_d;

  logic [AW-1:0]     clr_q, clr_d;
  logic [FUNC_W-1:0] func_q;
  logic [PAGE_W-1:0] page_q;
  logic [AW-1:0]     addr_q;
  logic [PAGE_W-1:0] head_q, head_d;
  logic              nonempty_q, nonempty_d;
  logic [FREE_W-1:0] free_q, free_d;
  logic              rsp_valid_q, rsp_valid_d;
  rpa_rsp_t          rsp_q, rsp_d;

  logic req_ready;
  logic accept;
  logic exec_go;
  logic clearing;

  // Memory ports.
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [AW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_rdata;
  logic          nxt_we;
  logic [NW-1:0] nxt_wdata;
  logic [AW-1:0] nxt_raddr;
  logic [NW-1:0] nxt_rdata;

  // Page numbers widened for range checks and memory addressing.
  logic [CMPW-1:0] req_page_ext;
  logic [CMPW-1:0] head_ext;
  logic [CMPW-1:0] page_ext;
  logic [CMPW-1:0] fup_ext;
  logic [AW-1:0]   req_addr;
  logic            in_range;

  // Execute-cycle results.
  logic          cnt_upd;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] cnt_out;
  logic          push_req;
  logic          pop_req;
  logic          push;
  logic [CW+REF_W-1:0] cnt_wide;

  assign req_page_ext = CMPW'(req_i.data.page);
  assign head_ext     = CMPW'(head_q);
  assign page_ext     = CMPW'(page_q);
  assign fup_ext      = CMPW'(cfg_i.first_usable_page);
  assign in_range     = (page_ext >= fup_ext) && (page_ext < PAGE_LIM);

  // Allocate reads the head page's count, every other operation its own page.
  assign req_addr  = (req_i.data.func == FUNC_ALLOC) ? head_ext[AW-1:0] : req_page_ext[AW-1:0];
  assign cnt_raddr = req_addr;
  assign nxt_raddr = head_ext[AW-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    req_ready = 1'b0;
    clearing  = 1'b0;
    exec_go   = 1'b0;
    unique case (state_q)
      ST_CLEAR: clearing  = 1'b1;
      ST_IDLE:  req_ready = 1'b1;
      ST_EXEC:  exec_go   = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign accept      = req_i.valid && req_ready;
  assign req_i.ready = req_ready;

  // Operation datapath, evaluated while the read data of the accepted word is present.
  always_comb begin
    cnt_upd    = 1'b0;
    cnt_new    = cnt_rdata;
    cnt_out    = '0;
    push_req   = 1'b0;
    pop_req    = 1'b0;
    head_d     = head_q;
    nonempty_d = nonempty_q;
    rsp_d      = '0;
    rsp_d.status = STATUS_OK;

    if (func_q == FUNC_ALLOC) begin
      if (nonempty_q) begin
        pop_req    = 1'b1;
        head_d     = nxt_rdata[PAGE_W-1:0];
        nonempty_d = nxt_rdata[PAGE_W];
        cnt_upd    = 1'b1;
        cnt_new    = COUNT_ONE;
        cnt_out    = COUNT_ONE;
        rsp_d.alloc_page = head_q;
      end else begin
        rsp_d.status = STATUS_NO_FREE;
      end
    end else if (func_q <= FUNC_READ) begin
      if (!in_range) begin
        rsp_d.status = STATUS_RANGE;
      end else begin
        case (func_q)
          FUNC_SEED: begin
            cnt_upd  = 1'b1;
            cnt_new  = '0;
            push_req = 1'b1;
          end
          FUNC_FREE: begin
            cnt_upd = 1'b1;
            if (cnt_rdata != '0) begin
              cnt_new = cnt_rdata - COUNT_ONE;
            end
            push_req = (cnt_new == '0);
          end
          FUNC_INC: begin
            if (cnt_rdata == COUNT_MAX) begin
              rsp_d.status = STATUS_LIMIT;
            end else begin
              cnt_upd = 1'b1;
              cnt_new = cnt_rdata + COUNT_ONE;
            end
          end
          FUNC_DEC: begin
            if (cnt_rdata == '0) begin
              rsp_d.status = STATUS_LIMIT;
            end else begin
              cnt_upd = 1'b1;
              cnt_new = cnt_rdata - COUNT_ONE;
            end
          end
          default: ;
        endcase
        cnt_out = cnt_new;
      end
    end

    // A push links the page in front of the current head.
    if (push_req) begin
      head_d     = page_q;
      nonempty_d = 1'b1;
    end

    free_d = free_q;
    if (push_req && (free_q != FREE_MAX)) begin
      free_d = free_q + FREE_W'(1);
    end else if (pop_req && (free_q != '0)) begin
      free_d = free_q - FREE_W'(1);
    end

    rsp_d.ref_count     = cnt_wide[REF_W-1:0];
    rsp_d.free_count    = free_d;
    rsp_d.page_released = push_req;
  end

  assign cnt_wide = (CW + REF_W)'(cnt_out);
  assign push     = exec_go && push_req;

  // Count memory write port: the clearing pass owns it after reset.
  always_comb begin
    if (clearing) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
    end else begin
      cnt_we    = exec_go && cnt_upd;
      cnt_waddr = addr_q;
      cnt_wdata = cnt_new;
    end
  end

  assign nxt_we    = push;
  assign nxt_wdata = {nonempty_q, head_q};

  // Clear counter.
  always_comb begin
    clr_d = clr_q;
    if (clearing && (clr_q != CLR_LAST)) begin
      clr_d = clr_q + AW'(1);
    end
  end

  // Result register handshake.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (exec_go) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      free_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      if (exec_go) begin
        head_q     <= head_d;
        nonempty_q <= nonempty_d;
        free_q     <= free_d;
      end
    end
  end

  // Accepted word and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.data.func;
      page_q <= req_i.data.page;
      addr_q <= req_addr;
    end
    if (exec_go) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Reference count per page, cleared by the pass after reset.
  rpa_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (accept),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // Free-list link per page: link-valid bit over the next page number.
  rpa_ram #(
    .WIDTH (NW),
    .DEPTH (NUM_PAGES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (addr_q),
    .wdata_i (nxt_wdata),
    .re_i    (accept),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  // An accepted word always moves the sequencer to its execute cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted word did not enter execute");

  // The clearing pass writes only zero counts.
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (cnt_we && (cnt_wdata == '0)))
    else $error("clearing pass wrote a nonzero count");

  // After a push the free list cannot be empty.
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> nonempty_q)
    else $error("free list empty after push");

  // A released page always comes with an ok status.
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.page_released) |-> (rsp_q.status == STATUS_OK))
    else $error("page released with error status");

endmodule

// File: src/refcounted_page_allocator.sv
// Reference-counted page allocator: APB configuration register and allocator core.
// A word is taken only in the idle state; the link and count memories are read as it is taken.
// The count update and the result load follow once the result register is free or being read;
// a new word is not taken before the result of the last one is loaded.
// After reset the count memory is cleared one entry a cycle, with no word accepted;
// configuration writes are taken throughout.
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 16384,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rpa_stream_if.sink   req_i,
  rpa_stream_if.source rsp_o
);
  import rpa_pkg::*;

  rpa_cfg_t cfg_q;
  logic     reg_wr;
  logic     reg_sel;

  // Register 0 sits at word address 0; other addresses are ignored.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_FIRST_USABLE);
  assign reg_wr  = psel && penable && pwrite && reg_sel;

  // First usable page register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (reg_wr) begin
      cfg_q.first_usable_page <= pwdata[PAGE_W-1:0];
    end
  end

  // Read-back of the register.
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = 32'(cfg_q.first_usable_page);
    end
  end

  rpa_core #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
